// ===== design/cmtl_pkg.sv =====
package cmtl_pkg;

  // Longest token that is passed on; later bytes of the token are dropped.
  localparam int unsigned MAX_TOKEN = 1023;
  localparam int unsigned LEN_W     = $clog2(MAX_TOKEN + 1);

  // Result queue between the scanner and the output side.
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    KIND_KEY   = 3'd0,
    KIND_NUM   = 3'd1,
    KIND_HEX   = 3'd2,
    KIND_ARRAY = 3'd3,
    KIND_NAME  = 3'd4,
    KIND_DICT  = 3'd5,
    KIND_END   = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       byte_valid;
    logic       last;
    logic       overflow;
  } result_t;

  // Up to two results produced by one accepted byte or end of stream, oldest in res0.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

// ===== design/cmtl_front.sv =====
module cmtl_front import cmtl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_stream_i,
  output push_t      push_o
);

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChLt      = 8'h3C;
  localparam logic [7:0] ChGt      = 8'h3E;
  localparam logic [7:0] ChLbrack  = 8'h5B;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChLf      = 8'h0A;

  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_COMMENT = 7'b0000010,
    M_LT      = 7'b0000100,
    M_HEX     = 7'b0001000,
    M_NUM     = 7'b0010000,
    M_NAME    = 7'b0100000,
    M_KEY     = 7'b1000000
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             drop_q, drop_d;

  function automatic logic is_blank(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic kind_e kind_of(mode_e m);
    kind_e k;
    case (m)
      M_HEX:   k = KIND_HEX;
      M_NUM:   k = KIND_NUM;
      M_NAME:  k = KIND_NAME;
      default: k = KIND_KEY;
    endcase
    return k;
  endfunction

  function automatic result_t mark(kind_e k, logic ovf);
    result_t r;
    r.kind       = k;
    r.data       = 8'h00;
    r.byte_valid = 1'b0;
    r.last       = 1'b1;
    r.overflow   = ovf;
    return r;
  endfunction

  logic             fresh;
  logic             do_store;
  logic             open_tok;
  logic [LEN_W-1:0] base_len;
  logic             base_drop;

  always_comb begin
    mode_d   = mode_q;
    len_d    = len_q;
    drop_d   = drop_q;
    fresh    = 1'b0;
    do_store = 1'b0;
    push_o   = '0;
    open_tok = (mode_q == M_HEX) || (mode_q == M_NUM) ||
               (mode_q == M_NAME) || (mode_q == M_KEY);

    if (end_of_stream_i) begin
      fresh  = 1'b1;
      mode_d = M_IDLE;
      if (open_tok) begin
        push_o.count = 2'd2;
        push_o.res0  = mark(kind_of(mode_q), drop_q);
        push_o.res1  = mark(KIND_END, 1'b0);
      end else begin
        push_o.count = 2'd1;
        push_o.res0  = mark(KIND_END, 1'b0);
      end
    end else begin
      case (mode_q)
        M_IDLE: begin
          if (is_blank(in_byte_i)) begin
            mode_d = M_IDLE;
          end else if (in_byte_i == ChPercent) begin
            mode_d = M_COMMENT;
          end else if (in_byte_i == ChLt) begin
            mode_d = M_LT;
          end else if (is_digit(in_byte_i)) begin
            mode_d   = M_NUM;
            fresh    = 1'b1;
            do_store = 1'b1;
          end else if (in_byte_i == ChLbrack) begin
            push_o.count = 2'd1;
            push_o.res0  = mark(KIND_ARRAY, 1'b0);
          end else if (in_byte_i == ChSlash) begin
            mode_d = M_NAME;
            fresh  = 1'b1;
          end else begin
            mode_d   = M_KEY;
            fresh    = 1'b1;
            do_store = 1'b1;
          end
        end
        M_COMMENT: begin
          if (in_byte_i == ChCr || in_byte_i == ChLf) begin
            mode_d = M_IDLE;
          end
        end
        M_LT: begin
          fresh = 1'b1;
          if (in_byte_i == ChLt) begin
            mode_d       = M_IDLE;
            push_o.count = 2'd1;
            push_o.res0  = mark(KIND_DICT, 1'b0);
          end else if (is_hex(in_byte_i)) begin
            mode_d   = M_HEX;
            do_store = 1'b1;
          end else begin
            mode_d = M_IDLE;
          end
        end
        M_HEX, M_NUM, M_NAME, M_KEY: begin
          if ((mode_q == M_HEX) ? (in_byte_i == ChGt) : is_blank(in_byte_i)) begin
            fresh        = 1'b1;
            mode_d       = M_IDLE;
            push_o.count = 2'd1;
            push_o.res0  = mark(kind_of(mode_q), drop_q);
          end else begin
            do_store = 1'b1;
          end
        end
        default: begin
          fresh  = 1'b1;
          mode_d = M_IDLE;
        end
      endcase
    end

    base_len  = fresh ? '0 : len_q;
    base_drop = fresh ? 1'b0 : drop_q;
    len_d     = base_len;
    drop_d    = base_drop;

    // Pass the byte on while there is room, otherwise drop it and flag.
    if (do_store) begin
      if (base_len < LEN_W'(MAX_TOKEN)) begin
        push_o.count           = 2'd1;
        push_o.res0.kind       = kind_of(mode_d);
        push_o.res0.data       = in_byte_i;
        push_o.res0.byte_valid = 1'b1;
        push_o.res0.last       = 1'b0;
        push_o.res0.overflow   = 1'b0;
        len_d                  = LEN_W'(base_len + 1'b1);
      end else begin
        drop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      len_q  <= '0;
      drop_q <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      len_q  <= len_d;
      drop_q <= drop_d;
    end
  end

endmodule

// ===== design/cmtl_queue.sv =====
module cmtl_queue import cmtl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  push_t             push_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output logic [QCNT_W-1:0] count_o,
  output result_t           head_o
);

  result_t           entry_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic [1:0]        n_wr;
  logic              do_pop;

  assign n_wr    = wr_en_i ? push_i.count : 2'd0;
  assign do_pop  = pop_i && !empty_o;
  assign empty_o = (cnt_q == '0);
  // Hold off the writer unless two slots are free.
  assign full_o  = (cnt_q > QCNT_W'(QDEPTH - 2));
  assign count_o = cnt_q;
  assign head_o  = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) begin
      entry_q[wptr_q] <= push_i.res0;
    end
    if (n_wr == 2'd2) begin
      entry_q[QPTR_W'(wptr_q + 1'b1)] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= QPTR_W'(wptr_q + n_wr);
      if (do_pop) begin
        rptr_q <= QPTR_W'(rptr_q + 1'b1);
      end
      cnt_q <= QCNT_W'(cnt_q + n_wr - {{(QCNT_W-1){1'b0}}, do_pop});
    end
  end

endmodule

// ===== design/cmap_token_lexer_top.sv =====
// Result words are registered in the result queue before they reach the result ports.
// Throughput: one byte per cycle while full is low; each byte yields at most one word, and an end of
//   stream that closes an open token yields two, which drain one per pop.
// full rises once fewer than two result queue slots are free.
// Reset (rst_ni low, asynchronous): scanner idle, token length and drop flag cleared,
//   result queue emptied.
module cmap_token_lexer_top import cmtl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_stream_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] token_kind_o,
  output logic [7:0] token_byte_o,
  output logic       byte_valid_o,
  output logic       token_last_o,
  output logic       overflow_o
);

  logic              accept;
  push_t             push_w;
  result_t           head;
  logic [QCNT_W-1:0] q_count;

  // A pushed byte is taken whenever the queue has room for the worst case of two words.
  assign accept = push && !full;

  // Front: classify each byte, track the scan mode and the token length.
  cmtl_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_byte_i       (in_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .push_o          (push_w)
  );

  // Back: queue the result words and present the oldest one.
  cmtl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (accept),
    .push_i  (push_w),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .count_o (q_count),
    .head_o  (head)
  );

  assign token_kind_o = head.kind;
  assign token_byte_o = head.data;
  assign byte_valid_o = head.byte_valid;
  assign token_last_o = head.last;
  assign overflow_o   = head.overflow;

  // The queue never holds more words than it has slots.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCNT_W'(QDEPTH))
    else $error("result queue count beyond depth");

  // An end of stream word always lands in the queue.
  a_eos_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_stream_i) |=> !empty)
    else $error("end of stream produced no word");

  // A shown word is either a token byte or a closing mark, never both.
  a_byte_xor_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (byte_valid_o != token_last_o))
    else $error("word is both byte and close");

  // Overflow is reported only on a closing word.
  a_ovf_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && overflow_o) |-> token_last_o)
    else $error("overflow on a byte word");

endmodule
